// File: rtl/core/mvl3_pkg.sv
// shared types, constants and helpers of the masked vector laplacian block
package mvl3_pkg;

	localparam int MAX_PLANES = 64;
	localparam int MAX_ROWS   = 64;
	localparam int MAX_COLS   = 64;

	localparam int PLANE_CELLS = MAX_ROWS * MAX_COLS;
	localparam int WIN_DEPTH   = 2 * PLANE_CELLS;
	localparam int PTR_W       = $clog2(WIN_DEPTH);
	localparam int NYZ_W       = $clog2(PLANE_CELLS + 1);
	localparam int TOT_W       = $clog2(MAX_PLANES * PLANE_CELLS + PLANE_CELLS + 1);
	localparam int COORD_W     = 6;
	localparam int SIZE_W      = 7;
	localparam int COEF_W      = 32;
	localparam int VEC_W       = 18;
	localparam int MAT_W       = 2;
	localparam int LAP_W       = 48;
	localparam int IDX_W       = 18;
	localparam int DIFF_W      = VEC_W + 1;
	localparam int PROD_W      = DIFF_W + COEF_W + 1;
	localparam int ACC_W       = PROD_W + 3;
	localparam int CELL_W      = 3 * VEC_W + MAT_W;
	localparam int NB_N        = 6;
	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 32;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_COEF_X = 3'd0;
	localparam logic [2:0] REG_COEF_Y = 3'd1;
	localparam logic [2:0] REG_COEF_Z = 3'd2;
	localparam logic [2:0] REG_SIZE_X = 3'd3;
	localparam logic [2:0] REG_SIZE_Y = 3'd4;
	localparam logic [2:0] REG_SIZE_Z = 3'd5;

	localparam logic [MAT_W-1:0] MAT_EMPTY = 2'd0;
	localparam logic [MAT_W-1:0] MAT_POS   = 2'd1;

	localparam logic       MODE_PAD  = 1'b1;

	localparam logic [COEF_W-1:0] COEF_RESET = 32'h0001_0000;
	localparam logic [SIZE_W-1:0] SIZE_MAX_X = SIZE_W'(MAX_PLANES);
	localparam logic [SIZE_W-1:0] SIZE_MAX_Y = SIZE_W'(MAX_ROWS);
	localparam logic [SIZE_W-1:0] SIZE_MAX_Z = SIZE_W'(MAX_COLS);

	localparam logic signed [ACC_W-1:0] SAT_HI =
		{{(ACC_W-LAP_W+1){1'b0}}, {(LAP_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

	typedef struct packed {
		logic [2:0][VEC_W-1:0] v;
		logic [MAT_W-1:0]      mat;
	} cell_t;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [DATA_W-1:0] val,
			input logic [SIZE_W-1:0] maxv);
		logic [SIZE_W-1:0] s;
		s = val[SIZE_W-1:0];
		if (s == '0)
			s = SIZE_W'(1);
		if (s > maxv)
			s = maxv;
		return s;
	endfunction

endpackage

// File: rtl/core/mvl3_ram.sv
// generic ram: one write port, two registered read ports, read-first
module mvl3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
		if (we)
			mem[waddr] <= wdata;
	end

endmodule

// File: rtl/core/masked_vector_laplacian_3d.sv
// top level: streaming masked seven-point vector laplacian over a 3d grid
// Cells stream in raster order (column fastest), one word per cycle while
// in_stall is low, and each result passes the stage 1, stage 2 and output
// registers after the word that completes it: the cell one plane (size_y*size_z
// words) earlier. Two ring buffers of 2*64*64 cells, each with two read ports,
// give the row and plane neighbours; the column neighbours and the centre come
// from a two-deep shift of one tap. Padding words (mode 1) after the last cell
// flush the final plane; padding inside a frame is dropped. The 18 products are
// formed in one stage and summed and saturated in the next; the result sits in
// an output register, and while it waits two more results can queue behind it
// before the input stalls. No clearing pass is needed.
module masked_vector_laplacian_3d (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          mode,
	input  logic signed [mvl3_pkg::VEC_W-1:0] vec_x,
	input  logic signed [mvl3_pkg::VEC_W-1:0] vec_y,
	input  logic signed [mvl3_pkg::VEC_W-1:0] vec_z,
	input  logic [mvl3_pkg::MAT_W-1:0]    material,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [mvl3_pkg::LAP_W-1:0] lap_x,
	output logic signed [mvl3_pkg::LAP_W-1:0] lap_y,
	output logic signed [mvl3_pkg::LAP_W-1:0] lap_z,
	output logic [mvl3_pkg::IDX_W-1:0]    cell_index,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mvl3_pkg::ADDR_W-1:0]   paddr,
	input  logic [mvl3_pkg::DATA_W-1:0]   pwdata,
	output logic [mvl3_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	// ---------------- configuration ----------------
	logic [mvl3_pkg::COEF_W-1:0] coef_x_q, coef_y_q, coef_z_q;
	logic [mvl3_pkg::SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
	logic [mvl3_pkg::SIZE_W-1:0] sx_n, sy_n, sz_n;
	logic [2*mvl3_pkg::SIZE_W-1:0] nyz_w;
	logic [mvl3_pkg::TOT_W-1:0]  total_w;
	logic [mvl3_pkg::NYZ_W-1:0]  nyz_q;
	logic [mvl3_pkg::TOT_W-1:0]  total_q, end_q;
	logic [mvl3_pkg::PTR_W-1:0]  d_ysub_q, d_yadd_q, d_x_q, d_z_q;
	logic [2:0]                  reg_idx;
	logic                        wr, size_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[mvl3_pkg::ADDR_W-1:2];
	assign wr      = psel && penable && pwrite && pready;
	assign size_wr = wr && (reg_idx == mvl3_pkg::REG_SIZE_X ||
		reg_idx == mvl3_pkg::REG_SIZE_Y || reg_idx == mvl3_pkg::REG_SIZE_Z);

	always_comb begin
		sx_n = size_x_q;
		sy_n = size_y_q;
		sz_n = size_z_q;
		if (wr) begin
			case (reg_idx)
				mvl3_pkg::REG_SIZE_X: sx_n = mvl3_pkg::clamp_size(pwdata, mvl3_pkg::SIZE_MAX_X);
				mvl3_pkg::REG_SIZE_Y: sy_n = mvl3_pkg::clamp_size(pwdata, mvl3_pkg::SIZE_MAX_Y);
				mvl3_pkg::REG_SIZE_Z: sz_n = mvl3_pkg::clamp_size(pwdata, mvl3_pkg::SIZE_MAX_Z);
				default: ;
			endcase
		end
		nyz_w   = (2*mvl3_pkg::SIZE_W)'(sy_n) * (2*mvl3_pkg::SIZE_W)'(sz_n);
		total_w = mvl3_pkg::TOT_W'(sx_n) * mvl3_pkg::TOT_W'(nyz_w);
	end

	always_comb begin
		case (reg_idx)
			mvl3_pkg::REG_COEF_X: prdata = coef_x_q;
			mvl3_pkg::REG_COEF_Y: prdata = coef_y_q;
			mvl3_pkg::REG_COEF_Z: prdata = coef_z_q;
			mvl3_pkg::REG_SIZE_X: prdata = mvl3_pkg::DATA_W'(size_x_q);
			mvl3_pkg::REG_SIZE_Y: prdata = mvl3_pkg::DATA_W'(size_y_q);
			mvl3_pkg::REG_SIZE_Z: prdata = mvl3_pkg::DATA_W'(size_z_q);
			default:              prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_x_q <= mvl3_pkg::COEF_RESET;
			coef_y_q <= mvl3_pkg::COEF_RESET;
			coef_z_q <= mvl3_pkg::COEF_RESET;
			size_x_q <= mvl3_pkg::SIZE_MAX_X;
			size_y_q <= mvl3_pkg::SIZE_MAX_Y;
			size_z_q <= mvl3_pkg::SIZE_MAX_Z;
			nyz_q    <= mvl3_pkg::NYZ_W'(mvl3_pkg::PLANE_CELLS);
			total_q  <= mvl3_pkg::TOT_W'(mvl3_pkg::MAX_PLANES * mvl3_pkg::PLANE_CELLS);
			end_q    <= mvl3_pkg::TOT_W'((mvl3_pkg::MAX_PLANES + 1) * mvl3_pkg::PLANE_CELLS);
			d_ysub_q <= mvl3_pkg::PTR_W'(mvl3_pkg::PLANE_CELLS - mvl3_pkg::MAX_COLS);
			d_yadd_q <= mvl3_pkg::PTR_W'(mvl3_pkg::PLANE_CELLS + mvl3_pkg::MAX_COLS);
			d_x_q    <= mvl3_pkg::PTR_W'(2 * mvl3_pkg::PLANE_CELLS);
			d_z_q    <= mvl3_pkg::PTR_W'(mvl3_pkg::PLANE_CELLS - 1);
		end else if (wr) begin
			case (reg_idx)
				mvl3_pkg::REG_COEF_X: coef_x_q <= pwdata;
				mvl3_pkg::REG_COEF_Y: coef_y_q <= pwdata;
				mvl3_pkg::REG_COEF_Z: coef_z_q <= pwdata;
				default: ;
			endcase
			if (size_wr) begin
				size_x_q <= sx_n;
				size_y_q <= sy_n;
				size_z_q <= sz_n;
				nyz_q    <= mvl3_pkg::NYZ_W'(nyz_w);
				total_q  <= total_w;
				end_q    <= total_w + mvl3_pkg::TOT_W'(nyz_w);
				d_ysub_q <= mvl3_pkg::PTR_W'(nyz_w - {7'd0, sz_n});
				d_yadd_q <= mvl3_pkg::PTR_W'(nyz_w + {7'd0, sz_n});
				d_x_q    <= mvl3_pkg::PTR_W'({nyz_w, 1'b0});
				d_z_q    <= mvl3_pkg::PTR_W'(nyz_w - 14'd1);
			end
		end
	end

	// ---------------- stage 0: accept, counters, ring access ----------------
	logic                         en1, en2, en3;
	logic                         v1_s1, v2_s2, v3_s3;
	logic                         emit_s1;
	logic                         accept, in_grid, counted, emit0;
	logic [mvl3_pkg::TOT_W-1:0]   arrival_q, arrival_inc;
	logic [mvl3_pkg::COORD_W-1:0] out_plane_q, out_row_q, out_col_q;
	logic [mvl3_pkg::PTR_W-1:0]   wp_q;
	mvl3_pkg::cell_t              cur;
	logic [mvl3_pkg::NB_N-1:0]    mask0;
	logic [mvl3_pkg::CELL_W-1:0]  rd_yp, rd_ym, rd_xm, rd_zp;

	assign en3      = !v3_s3 || !out_stall;
	assign en2      = !v2_s2 || en3;
	assign en1      = !v1_s1 || !emit_s1 || en2;
	assign in_stall = !en1;

	assign accept      = in_valid && !in_stall;
	assign in_grid     = arrival_q < total_q;
	// padding inside the frame is swallowed without counting
	assign counted     = accept && !(in_grid && mode == mvl3_pkg::MODE_PAD);
	assign emit0       = arrival_q >= mvl3_pkg::TOT_W'(nyz_q);
	assign arrival_inc = arrival_q + mvl3_pkg::TOT_W'(1);

	assign cur.v[0] = vec_x;
	assign cur.v[1] = vec_y;
	assign cur.v[2] = vec_z;
	assign cur.mat  = material;

	// neighbour order: col-, col+, row-, row+, plane-, plane+
	assign mask0[0] = out_col_q != '0;
	assign mask0[1] = ({1'b0, out_col_q} + 7'd1) < size_z_q;
	assign mask0[2] = out_row_q != '0;
	assign mask0[3] = ({1'b0, out_row_q} + 7'd1) < size_y_q;
	assign mask0[4] = out_plane_q != '0;
	assign mask0[5] = (({1'b0, out_plane_q} + 7'd1) < size_x_q) && in_grid;

	mvl3_ram #(.WIDTH(mvl3_pkg::CELL_W), .DEPTH(mvl3_pkg::WIN_DEPTH)) u_ram_y (
		.clk     (clk),
		.we      (counted),
		.waddr   (wp_q),
		.wdata   (cur),
		.re      (counted),
		.raddr_a (wp_q - d_ysub_q),
		.raddr_b (wp_q - d_yadd_q),
		.rdata_a (rd_yp),
		.rdata_b (rd_ym)
	);

	mvl3_ram #(.WIDTH(mvl3_pkg::CELL_W), .DEPTH(mvl3_pkg::WIN_DEPTH)) u_ram_xz (
		.clk     (clk),
		.we      (counted),
		.waddr   (wp_q),
		.wdata   (cur),
		.re      (counted),
		.raddr_a (wp_q - d_x_q),
		.raddr_b (wp_q - d_z_q),
		.rdata_a (rd_xm),
		.rdata_b (rd_zp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arrival_q   <= '0;
			out_plane_q <= '0;
			out_row_q   <= '0;
			out_col_q   <= '0;
			wp_q        <= '0;
		end else if (size_wr) begin
			arrival_q   <= '0;
			out_plane_q <= '0;
			out_row_q   <= '0;
			out_col_q   <= '0;
		end else if (counted) begin
			wp_q <= wp_q + mvl3_pkg::PTR_W'(1);
			if (arrival_inc >= end_q) begin
				arrival_q   <= '0;
				out_plane_q <= '0;
				out_row_q   <= '0;
				out_col_q   <= '0;
			end else begin
				arrival_q <= arrival_inc;
				if (emit0) begin
					if (({1'b0, out_col_q} + 7'd1) >= size_z_q) begin
						out_col_q <= '0;
						if (({1'b0, out_row_q} + 7'd1) >= size_y_q) begin
							out_row_q   <= '0;
							out_plane_q <= out_plane_q + mvl3_pkg::COORD_W'(1);
						end else begin
							out_row_q <= out_row_q + mvl3_pkg::COORD_W'(1);
						end
					end else begin
						out_col_q <= out_col_q + mvl3_pkg::COORD_W'(1);
					end
				end
			end
		end
	end

	// ---------------- stage 1: neighbours, products ----------------
	mvl3_pkg::cell_t             cur_s1;
	logic                        bypass_s1;
	logic [mvl3_pkg::NB_N-1:0]   mask_s1;
	logic [mvl3_pkg::IDX_W-1:0]  idx_s1;
	mvl3_pkg::cell_t             hold1_q, hold2_q;
	mvl3_pkg::cell_t             nb [mvl3_pkg::NB_N];
	logic [mvl3_pkg::COEF_W-1:0] coef_c [mvl3_pkg::NB_N];
	logic signed [mvl3_pkg::DIFF_W-1:0] diff_c [mvl3_pkg::NB_N][3];
	logic signed [mvl3_pkg::PROD_W-1:0] prod_c [mvl3_pkg::NB_N][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1   <= 1'b0;
			emit_s1 <= 1'b0;
		end else if (en1) begin
			v1_s1   <= counted;
			emit_s1 <= emit0;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && counted) begin
			cur_s1    <= cur;
			bypass_s1 <= d_z_q == '0;
			mask_s1   <= mask0;
			idx_s1    <= mvl3_pkg::IDX_W'(arrival_q - mvl3_pkg::TOT_W'(nyz_q));
		end
		// column window shifts once per counted word
		if (en1 && v1_s1) begin
			hold2_q <= hold1_q;
			hold1_q <= nb[1];
		end
	end

	always_comb begin
		nb[0] = hold2_q;
		// a zero-length tap is the word arriving now
		nb[1] = bypass_s1 ? cur_s1 : mvl3_pkg::cell_t'(rd_zp);
		nb[2] = mvl3_pkg::cell_t'(rd_ym);
		nb[3] = mvl3_pkg::cell_t'(rd_yp);
		nb[4] = mvl3_pkg::cell_t'(rd_xm);
		nb[5] = cur_s1;
		coef_c[0] = coef_z_q;
		coef_c[1] = coef_z_q;
		coef_c[2] = coef_y_q;
		coef_c[3] = coef_y_q;
		coef_c[4] = coef_x_q;
		coef_c[5] = coef_x_q;
		for (int t = 0; t < mvl3_pkg::NB_N; t++) begin
			for (int k = 0; k < 3; k++) begin
				diff_c[t][k] = {nb[t].v[k][mvl3_pkg::VEC_W-1], nb[t].v[k]} -
					{hold1_q.v[k][mvl3_pkg::VEC_W-1], hold1_q.v[k]};
				if (mask_s1[t] && nb[t].mat == mvl3_pkg::MAT_POS &&
						hold1_q.mat != mvl3_pkg::MAT_EMPTY)
					prod_c[t][k] = diff_c[t][k] * $signed({1'b0, coef_c[t]});
				else
					prod_c[t][k] = '0;
			end
		end
	end

	// ---------------- stage 2: sum and saturate ----------------
	logic signed [mvl3_pkg::PROD_W-1:0] prod_s2 [mvl3_pkg::NB_N][3];
	logic [mvl3_pkg::IDX_W-1:0]         idx_s2;
	logic signed [mvl3_pkg::ACC_W-1:0]  acc_c [3];
	logic signed [mvl3_pkg::LAP_W-1:0]  sat_c [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v2_s2 <= 1'b0;
		else if (en2)
			v2_s2 <= v1_s1 && emit_s1;
	end

	always_ff @(posedge clk) begin
		if (en2 && v1_s1 && emit_s1) begin
			prod_s2 <= prod_c;
			idx_s2  <= idx_s1;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			acc_c[k] = '0;
			for (int t = 0; t < mvl3_pkg::NB_N; t++)
				acc_c[k] = acc_c[k] + mvl3_pkg::ACC_W'(prod_s2[t][k]);
			if (acc_c[k] > mvl3_pkg::SAT_HI)
				sat_c[k] = mvl3_pkg::LAP_W'(mvl3_pkg::SAT_HI);
			else if (acc_c[k] < mvl3_pkg::SAT_LO)
				sat_c[k] = mvl3_pkg::LAP_W'(mvl3_pkg::SAT_LO);
			else
				sat_c[k] = mvl3_pkg::LAP_W'(acc_c[k]);
		end
	end

	// ---------------- stage 3: output register ----------------
	logic signed [mvl3_pkg::LAP_W-1:0] lap_s3 [3];
	logic [mvl3_pkg::IDX_W-1:0]        idx_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v3_s3 <= 1'b0;
		else if (en3)
			v3_s3 <= v2_s2;
	end

	always_ff @(posedge clk) begin
		if (en3 && v2_s2) begin
			lap_s3 <= sat_c;
			idx_s3 <= idx_s2;
		end
	end

	assign out_valid  = v3_s3;
	assign lap_x      = lap_s3[0];
	assign lap_y      = lap_s3[1];
	assign lap_z      = lap_s3[2];
	assign cell_index = idx_s3;

endmodule

// File: rtl/core/mvl3_chk.sv
// port-level checker for the masked vector laplacian block, with its bind
module mvl3_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [mvl3_pkg::IDX_W-1:0]  cell_index,
	input logic [mvl3_pkg::LAP_W-1:0]  lap_x,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic                        pready
);

	logic                       seen_q;
	logic [mvl3_pkg::IDX_W-1:0] last_idx_q;
	logic                       out_acc;

	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= 1'b0;
			last_idx_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			seen_q <= 1'b0;
		end else if (out_acc) begin
			seen_q     <= 1'b1;
			last_idx_q <= cell_index;
		end
	end

	// results come out in raster order, restarting at zero
	a_idx_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && seen_q |->
			cell_index == last_idx_q + mvl3_pkg::IDX_W'(1) || cell_index == '0)
		else $error("result word out of raster order");

	// an empty output side never holds back the input
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output side empty");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cell_index) && $stable(lap_x))
		else $error("stalled result word changed");

endmodule

bind masked_vector_laplacian_3d mvl3_chk u_mvl3_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.cell_index (cell_index),
	.lap_x      (lap_x),
	.psel       (psel),
	.penable    (penable),
	.pwrite     (pwrite),
	.pready     (pready)
);

// File: test/masked_vector_laplacian_3d_tb.sv
// self-checking testbench of the masked vector laplacian block
module masked_vector_laplacian_3d_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct {
		logic                              mode;
		logic signed [mvl3_pkg::VEC_W-1:0] vx, vy, vz;
		logic [mvl3_pkg::MAT_W-1:0]        mat;
	} word_t;

	typedef struct {
		logic [mvl3_pkg::LAP_W-1:0] lx, ly, lz;
		logic [mvl3_pkg::IDX_W-1:0] idx;
	} lap_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, in_stall;
	logic mode = 1'b0;
	logic signed [mvl3_pkg::VEC_W-1:0] vec_x = '0, vec_y = '0, vec_z = '0;
	logic [mvl3_pkg::MAT_W-1:0] material = '0;
	logic out_valid, out_stall = 1'b0;
	logic signed [mvl3_pkg::LAP_W-1:0] lap_x, lap_y, lap_z;
	logic [mvl3_pkg::IDX_W-1:0] cell_index;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [mvl3_pkg::ADDR_W-1:0] paddr = '0;
	logic [mvl3_pkg::DATA_W-1:0] pwdata = '0;
	logic [mvl3_pkg::DATA_W-1:0] prdata;
	logic pready;

	masked_vector_laplacian_3d dut (.*);

	always #10 clk = ~clk;

	// predictor state
	logic [mvl3_pkg::COEF_W-1:0] cx, cy, cz;
	int unsigned sx, sy, sz;
	logic signed [mvl3_pkg::VEC_W-1:0] win_v [mvl3_pkg::WIN_DEPTH][3];
	logic [mvl3_pkg::MAT_W-1:0] win_m [mvl3_pkg::WIN_DEPTH];
	int unsigned arrivals, op, orow, ocol;

	word_t pending_words[$];
	lap_t expected_laps[$];
	int errors = 0;
	int cycles = 0;
	bit hold_off = 1'b0;
	bit sender_on = 1'b0;
	int burst_left = 0, gap_left = 0;

	function automatic int unsigned win_slot(int unsigned p, r, c);
		return ((p % 2) * mvl3_pkg::MAX_ROWS + r) * mvl3_pkg::MAX_COLS + c;
	endfunction

	function automatic int unsigned clamp_sz(logic [mvl3_pkg::DATA_W-1:0] v, int unsigned m);
		int unsigned s;
		s = 32'(v[mvl3_pkg::SIZE_W-1:0]);
		if (s == 0) s = 1;
		if (s > m) s = m;
		return s;
	endfunction

	function automatic void add_nb(ref longint acc[3], input int unsigned ctr,
			input logic signed [mvl3_pkg::VEC_W-1:0] nv[3],
			input logic [mvl3_pkg::MAT_W-1:0] nm,
			input logic [mvl3_pkg::COEF_W-1:0] coef);
		if (nm != mvl3_pkg::MAT_POS) return;
		for (int k = 0; k < 3; k++)
			acc[k] += (longint'(nv[k]) - longint'(win_v[ctr][k])) * longint'({1'b0, coef});
	endfunction

	function automatic void predict_laplacian(word_t w);
		int unsigned nyz, total, a, ctr, p, rem;
		bit in_grid;
		longint acc[3];
		longint s;
		logic signed [mvl3_pkg::VEC_W-1:0] cv[3];
		lap_t res;
		logic [mvl3_pkg::LAP_W-1:0] outv[3];
		nyz = sy * sz;
		total = sx * nyz;
		a = arrivals;
		in_grid = a < total;
		if (in_grid && w.mode == mvl3_pkg::MODE_PAD) return;
		cv[0] = w.vx; cv[1] = w.vy; cv[2] = w.vz;
		if (a >= nyz) begin
			ctr = win_slot(op, orow, ocol);
			acc = '{0, 0, 0};
			if (win_m[ctr] != mvl3_pkg::MAT_EMPTY) begin
				if (ocol > 0)
					add_nb(acc, ctr, win_v[win_slot(op, orow, ocol-1)],
						win_m[win_slot(op, orow, ocol-1)], cz);
				if (orow > 0)
					add_nb(acc, ctr, win_v[win_slot(op, orow-1, ocol)],
						win_m[win_slot(op, orow-1, ocol)], cy);
				if (op > 0)
					add_nb(acc, ctr, win_v[win_slot(op+1, orow, ocol)],
						win_m[win_slot(op+1, orow, ocol)], cx);
				if (op + 1 < sx && in_grid) add_nb(acc, ctr, cv, w.mat, cx);
				if (orow + 1 < sy)
					add_nb(acc, ctr, win_v[win_slot(op, orow+1, ocol)],
						win_m[win_slot(op, orow+1, ocol)], cy);
				if (ocol + 1 < sz)
					add_nb(acc, ctr, win_v[win_slot(op, orow, ocol+1)],
						win_m[win_slot(op, orow, ocol+1)], cz);
			end
			for (int k = 0; k < 3; k++) begin
				s = acc[k];
				if (s > 64'sd140737488355327) s = 64'sd140737488355327;
				if (s < -64'sd140737488355328) s = -64'sd140737488355328;
				outv[k] = s[mvl3_pkg::LAP_W-1:0];
			end
			res.lx = outv[0]; res.ly = outv[1]; res.lz = outv[2];
			res.idx = mvl3_pkg::IDX_W'(op * nyz + orow * sz + ocol);
			expected_laps.push_back(res);
			ocol++;
			if (ocol >= sz) begin
				ocol = 0;
				orow++;
				if (orow >= sy) begin
					orow = 0;
					op++;
				end
			end
		end
		if (in_grid) begin
			p = a / nyz;
			rem = a % nyz;
			win_v[win_slot(p, rem / sz, rem % sz)] = cv;
			win_m[win_slot(p, rem / sz, rem % sz)] = w.mat;
		end
		arrivals = a + 1;
		if (arrivals >= total + nyz) begin
			arrivals = 0; op = 0; orow = 0; ocol = 0;
		end
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [mvl3_pkg::DATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= mvl3_pkg::ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			mvl3_pkg::REG_COEF_X: cx = val;
			mvl3_pkg::REG_COEF_Y: cy = val;
			mvl3_pkg::REG_COEF_Z: cz = val;
			mvl3_pkg::REG_SIZE_X: sx = clamp_sz(val, mvl3_pkg::MAX_PLANES);
			mvl3_pkg::REG_SIZE_Y: sy = clamp_sz(val, mvl3_pkg::MAX_ROWS);
			mvl3_pkg::REG_SIZE_Z: sz = clamp_sz(val, mvl3_pkg::MAX_COLS);
			default: ;
		endcase
		if (idx >= mvl3_pkg::REG_SIZE_X) begin
			arrivals = 0; op = 0; orow = 0; ocol = 0;
		end
	endtask

	function automatic logic signed [mvl3_pkg::VEC_W-1:0] rand_vec();
		case ($urandom_range(0, 5))
			0: return 18'sh1FFFF;
			1: return -18'sh20000;
			default: return mvl3_pkg::VEC_W'($urandom);
		endcase
	endfunction

	function automatic word_t rand_cell();
		word_t w;
		w.mode = 1'b0;
		w.vx = rand_vec(); w.vy = rand_vec(); w.vz = rand_vec();
		w.mat = ($urandom_range(0, 9) < 6) ? mvl3_pkg::MAT_POS :
			mvl3_pkg::MAT_W'($urandom_range(0, 3));
		return w;
	endfunction

	function automatic word_t pad_word();
		word_t w;
		w = rand_cell();
		w.mode = mvl3_pkg::MODE_PAD;
		return w;
	endfunction

	// cells of one full frame, stray padding inside, then one plane of flush
	function automatic void queue_frame(int noise);
		int unsigned n;
		n = sx * sy * sz;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < noise) pending_words.push_back(pad_word());
			pending_words.push_back(rand_cell());
		end
		for (int i = 0; i < sy * sz; i++)
			pending_words.push_back(($urandom_range(0, 3) == 0) ? rand_cell() : pad_word());
	endfunction

	task automatic wait_idle();
		while (pending_words.size() != 0 || in_valid || expected_laps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// driver
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			predict_laplacian(pending_words.pop_front());
		end
		if (!in_valid || !in_stall) begin
			if (burst_left > 0) begin
				burst_left--;
			end else if (gap_left > 0) begin
				gap_left--;
			end else begin
				burst_left = $urandom_range(1, 40);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
			end
			sender_on = (burst_left > 0);
			if (sender_on && pending_words.size() != 0) begin
				in_valid <= 1'b1;
				mode <= pending_words[0].mode;
				vec_x <= pending_words[0].vx;
				vec_y <= pending_words[0].vy;
				vec_z <= pending_words[0].vz;
				material <= pending_words[0].mat;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		lap_t e;
		cycles++;
		if (out_valid && !out_stall) begin
			if (expected_laps.size() == 0) begin
				$display("%0t unexpected word idx=%0d", $realtime, cell_index);
				errors++;
			end else begin
				e = expected_laps.pop_front();
				if (lap_x !== e.lx || lap_y !== e.ly || lap_z !== e.lz
						|| cell_index !== e.idx) begin
					$display("%0t mismatch exp %h %h %h idx %0d got %h %h %h idx %0d",
						$realtime, e.lx, e.ly, e.lz, e.idx,
						lap_x, lap_y, lap_z, cell_index);
					errors++;
				end
			end
		end
		if (hold_off) out_stall <= 1'b1;
		else out_stall <= ($urandom_range(0, 7) < 2) && (cycles % 300 > 120);
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// long receiver hold-off, counted here
	initial begin
		wait (cycles > 2000);
		hold_off = 1'b1;
		repeat (400) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		word_t w;
		cx = mvl3_pkg::COEF_RESET; cy = mvl3_pkg::COEF_RESET; cz = mvl3_pkg::COEF_RESET;
		sx = mvl3_pkg::MAX_PLANES; sy = mvl3_pkg::MAX_ROWS; sz = mvl3_pkg::MAX_COLS;
		arrivals = 0; op = 0; orow = 0; ocol = 0;
		for (int i = 0; i < mvl3_pkg::WIN_DEPTH; i++) begin
			win_v[i] = '{0, 0, 0};
			win_m[i] = mvl3_pkg::MAT_EMPTY;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: 2x2x2 grid, extreme vectors, all materials, max x coef, zero y coef
		write_reg(mvl3_pkg::REG_COEF_X, 32'hFFFF_FFFF);
		write_reg(mvl3_pkg::REG_COEF_Y, 32'h0000_0000);
		write_reg(mvl3_pkg::REG_COEF_Z, 32'h0001_0000);
		write_reg(mvl3_pkg::REG_SIZE_X, 2);
		write_reg(mvl3_pkg::REG_SIZE_Y, 2);
		write_reg(mvl3_pkg::REG_SIZE_Z, 2);
		pending_words.push_back(pad_word());  // padding before grid complete
		for (int i = 0; i < 8; i++) begin
			w.mode = 1'b0;
			w.vx = (i % 2) ? 18'sh1FFFF : -18'sh20000;
			w.vy = (i % 2) ? -18'sh20000 : 18'sh1FFFF;
			w.vz = mvl3_pkg::VEC_W'(i * 1000);
			w.mat = mvl3_pkg::MAT_W'(i % 4);
			if (i == 0 || i == 7) w.mat = mvl3_pkg::MAT_POS;
			pending_words.push_back(w);
		end
		pending_words.push_back(rand_cell());  // cell past grid acts as padding
		for (int i = 0; i < 3; i++) pending_words.push_back(pad_word());
		wait_idle();
		// size clamping: zero and oversize
		write_reg(mvl3_pkg::REG_SIZE_X, 0);
		write_reg(mvl3_pkg::REG_SIZE_Y, 32'h7F);
		write_reg(mvl3_pkg::REG_SIZE_Z, 32'h80);
		write_reg(mvl3_pkg::REG_SIZE_Y, 1);
		write_reg(mvl3_pkg::REG_SIZE_Z, 64);
		queue_frame(0);
		wait_idle();
		// random phases with small grids
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(mvl3_pkg::REG_COEF_X, (ph % 3 == 0) ? 32'hFFFF_FFFF : $urandom);
			write_reg(mvl3_pkg::REG_COEF_Y,
				(ph % 4 == 1) ? 32'h0 : $urandom_range(0, 32'h0004_0000));
			write_reg(mvl3_pkg::REG_COEF_Z, $urandom);
			write_reg(mvl3_pkg::REG_SIZE_X, $urandom_range(1, 5));
			write_reg(mvl3_pkg::REG_SIZE_Y, $urandom_range(1, 6));
			write_reg(mvl3_pkg::REG_SIZE_Z, $urandom_range(1, 8));
			for (int f = 0; f < 2; f++) queue_frame(5);
			wait_idle();
		end
		// 1x4x64 grid with full-length rows so the block can fill while stalled
		write_reg(mvl3_pkg::REG_SIZE_X, 1);
		write_reg(mvl3_pkg::REG_SIZE_Y, 4);
		write_reg(mvl3_pkg::REG_SIZE_Z, 64);
		queue_frame(2);
		wait_idle();
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: files.f
rtl/core/mvl3_pkg.sv
rtl/core/mvl3_ram.sv
rtl/core/masked_vector_laplacian_3d.sv
rtl/core/mvl3_chk.sv
test/masked_vector_laplacian_3d_tb.sv
